>>> sv/mrnp_pkg.sv
// Package for the multi-radix number text parser.
// Holds field widths, limits, character and status codes, phase and start types.
// No dependencies.
package mrnp_pkg;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;

	typedef logic [CHAR_W-1:0]   char_t;
	typedef logic [VALUE_W-1:0]  value_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_NONE = 2'd1;
	localparam status_t ST_OVF  = 2'd2;

	localparam value_t OVF_VALUE = 32'h00ff_ffff;
	localparam value_t DEC_LIMIT = 32'd429496729;

	localparam char_t CH_NUL   = 8'h00;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_0     = 8'h30;
	localparam char_t CH_1     = 8'h31;
	localparam char_t CH_5     = 8'h35;
	localparam char_t CH_7     = 8'h37;
	localparam char_t CH_9     = 8'h39;
	localparam char_t CH_UA    = 8'h41;
	localparam char_t CH_UB    = 8'h42;
	localparam char_t CH_UF    = 8'h46;
	localparam char_t CH_UX    = 8'h58;
	localparam char_t CH_LA    = 8'h61;
	localparam char_t CH_LB    = 8'h62;
	localparam char_t CH_LF    = 8'h66;
	localparam char_t CH_LX    = 8'h78;

	// Scan phase, one-hot
	typedef enum logic [8:0] {
		PH_SKIP      = 9'b0_0000_0001,
		PH_ZERO      = 9'b0_0000_0010,
		PH_HEX_FIRST = 9'b0_0000_0100,
		PH_HEX       = 9'b0_0000_1000,
		PH_OCT       = 9'b0_0001_0000,
		PH_BIN_FIRST = 9'b0_0010_0000,
		PH_BIN       = 9'b0_0100_0000,
		PH_DEC       = 9'b0_1000_0000,
		PH_HALT      = 9'b1_0000_0000
	} phase_t;

	// Outcome of starting a new scan on a byte
	typedef enum logic [2:0] {
		START_GO   = 3'b001,
		START_END  = 3'b010,
		START_FAIL = 3'b100
	} start_t;

endpackage

>>> sv/mrnp_if.sv
// Valid/ready channel interfaces of the multi-radix number text parser.
// Depends on mrnp_pkg for the payload types.
interface mrnp_in_if;
	logic           valid;
	logic           ready;
	mrnp_pkg::char_t char_in;

	modport source (output valid, output char_in, input ready);
	modport sink   (input valid, input char_in, output ready);
endinterface

interface mrnp_out_if;
	logic              valid;
	logic              ready;
	mrnp_pkg::value_t  value;
	mrnp_pkg::status_t status;
	logic              end_of_scan;

	modport source (output valid, output value, output status, output end_of_scan, input ready);
	modport sink   (input valid, input value, input status, input end_of_scan, output ready);
endinterface

>>> sv/multi_radix_number_text_parser.sv
// Multi-radix number text parser, top level.
// Depends on mrnp_pkg and the channel interfaces in mrnp_if.sv.
//
// Takes one text byte per item and reports unsigned 32-bit numbers found in it
// (decimal, 0x hex, leading-0 octal, b binary), at most one result per byte.
// Throughput is one byte per clock: each byte is registered, then a single pass
// of phase update and shift-add (the decimal times-ten add sets the path) writes
// the phase, the accumulator and the output register. The output register lets
// the next byte in while no result waits or the waiting one is taken in the same
// cycle; a stalled result holds back input as soon as a byte sits in the input
// register.
module multi_radix_number_text_parser (
	input  logic          clk,
	input  logic          arst_n,
	mrnp_in_if.sink       in_ch,
	mrnp_out_if.source    out_ch
);
	import mrnp_pkg::*;

	logic    valid_s1;
	char_t   char_s1;
	phase_t  phase_q, phase_d;
	value_t  acc_q, acc_d;
	logic    out_valid_q;
	value_t  out_value_q;
	status_t out_status_q;
	logic    out_eos_q;
	logic    advance;

	logic    emit;
	value_t  emit_value;
	status_t emit_status;
	logic    emit_eos;

	phase_t  start_phase;
	value_t  start_acc;
	start_t  start_kind;

	logic        is_dec, is_oct, is_bin, is_hex, is_x, is_b;
	logic [3:0]  digit;
	value_t      dec_next;

	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			char_s1 <= in_ch.char_in;
		end
	end

	// Character classes
	always_comb begin
		is_dec = (char_s1 >= CH_0) && (char_s1 <= CH_9);
		is_oct = (char_s1 >= CH_0) && (char_s1 <= CH_7);
		is_bin = (char_s1 == CH_0) || (char_s1 == CH_1);
		is_hex = is_dec || ((char_s1 >= CH_UA) && (char_s1 <= CH_UF))
			|| ((char_s1 >= CH_LA) && (char_s1 <= CH_LF));
		is_x   = (char_s1 == CH_LX) || (char_s1 == CH_UX);
		is_b   = (char_s1 == CH_LB) || (char_s1 == CH_UB);
		// letters A-F and a-f have their low nibble at 1..6
		digit  = is_dec ? char_s1[3:0] : char_s1[3:0] + 4'd9;
		dec_next = {acc_q[VALUE_W-4:0], 3'b000} + {acc_q[VALUE_W-2:0], 1'b0}
			+ {{(VALUE_W-4){1'b0}}, digit};
	end

	// Outcome of letting the current byte start a new scan
	always_comb begin
		start_acc = '0;
		priority if (char_s1 == CH_NUL) begin
			start_phase = PH_SKIP;
			start_kind  = START_END;
		end else if (char_s1 <= CH_SPACE) begin
			start_phase = PH_SKIP;
			start_kind  = START_GO;
		end else if (char_s1 == CH_0) begin
			start_phase = PH_ZERO;
			start_kind  = START_GO;
		end else if (is_b) begin
			start_phase = PH_BIN_FIRST;
			start_kind  = START_GO;
		end else if (is_dec) begin
			start_phase = PH_DEC;
			start_acc   = {{(VALUE_W-4){1'b0}}, digit};
			start_kind  = START_GO;
		end else begin
			start_phase = PH_HALT;
			start_kind  = START_FAIL;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		acc_d       = acc_q;
		emit        = 1'b0;
		emit_value  = '0;
		emit_status = ST_OK;
		emit_eos    = 1'b0;
		unique case (phase_q)
			PH_ZERO: begin
				if (is_x) begin
					phase_d = PH_HEX_FIRST;
					acc_d   = '0;
				end else if (is_oct) begin
					phase_d = PH_OCT;
					acc_d   = {{(VALUE_W-4){1'b0}}, digit};
				end else begin
					phase_d    = start_phase;
					acc_d      = start_acc;
					emit       = 1'b1;
					emit_value = '0;
					emit_eos   = (start_kind != START_GO);
				end
			end
			PH_HEX_FIRST, PH_HEX: begin
				if (is_hex) begin
					if (acc_q[VALUE_W-1 -: 4] != 4'd0) begin
						phase_d     = PH_HALT;
						acc_d       = '0;
						emit        = 1'b1;
						emit_value  = OVF_VALUE;
						emit_status = ST_OVF;
						emit_eos    = 1'b1;
					end else begin
						phase_d = PH_HEX;
						acc_d   = {acc_q[VALUE_W-5:0], digit};
					end
				end else if (phase_q == PH_HEX_FIRST) begin
					phase_d     = (char_s1 == CH_NUL) ? PH_SKIP : PH_HALT;
					acc_d       = '0;
					emit        = 1'b1;
					emit_status = ST_NONE;
					emit_eos    = 1'b1;
				end else begin
					phase_d    = start_phase;
					acc_d      = start_acc;
					emit       = 1'b1;
					emit_value = acc_q;
					emit_eos   = (start_kind != START_GO);
				end
			end
			PH_OCT: begin
				if (is_oct) begin
					if (acc_q[VALUE_W-1 -: 3] != 3'd0) begin
						phase_d     = PH_HALT;
						acc_d       = '0;
						emit        = 1'b1;
						emit_value  = OVF_VALUE;
						emit_status = ST_OVF;
						emit_eos    = 1'b1;
					end else begin
						acc_d = {acc_q[VALUE_W-4:0], digit[2:0]};
					end
				end else begin
					phase_d    = start_phase;
					acc_d      = start_acc;
					emit       = 1'b1;
					emit_value = acc_q;
					emit_eos   = (start_kind != START_GO);
				end
			end
			PH_BIN_FIRST, PH_BIN: begin
				if (is_bin) begin
					if (acc_q[VALUE_W-1]) begin
						phase_d     = PH_HALT;
						acc_d       = '0;
						emit        = 1'b1;
						emit_value  = OVF_VALUE;
						emit_status = ST_OVF;
						emit_eos    = 1'b1;
					end else begin
						phase_d = PH_BIN;
						acc_d   = {acc_q[VALUE_W-2:0], digit[0]};
					end
				end else if (phase_q == PH_BIN_FIRST) begin
					phase_d     = (char_s1 == CH_NUL) ? PH_SKIP : PH_HALT;
					acc_d       = '0;
					emit        = 1'b1;
					emit_status = ST_NONE;
					emit_eos    = 1'b1;
				end else begin
					phase_d    = start_phase;
					acc_d      = start_acc;
					emit       = 1'b1;
					emit_value = acc_q;
					emit_eos   = (start_kind != START_GO);
				end
			end
			PH_DEC: begin
				if (is_dec) begin
					if ((acc_q > DEC_LIMIT) || ((acc_q == DEC_LIMIT) && (char_s1 > CH_5))) begin
						phase_d     = PH_HALT;
						acc_d       = '0;
						emit        = 1'b1;
						emit_value  = OVF_VALUE;
						emit_status = ST_OVF;
						emit_eos    = 1'b1;
					end else begin
						acc_d = dec_next;
					end
				end else begin
					phase_d    = start_phase;
					acc_d      = start_acc;
					emit       = 1'b1;
					emit_value = acc_q;
					emit_eos   = (start_kind != START_GO);
				end
			end
			PH_HALT: begin
				// drop everything until the string ends
				if (char_s1 == CH_NUL) begin
					phase_d = PH_SKIP;
					acc_d   = '0;
				end
			end
			default: begin
				phase_d = start_phase;
				acc_d   = start_acc;
				if (start_kind != START_GO) begin
					emit        = 1'b1;
					emit_status = ST_NONE;
					emit_eos    = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SKIP;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (advance && emit) || (out_valid_q && !out_ch.ready);
			if (advance) begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_value_q  <= emit_value;
			out_status_q <= emit_status;
			out_eos_q    <= emit_eos;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.value       = out_value_q;
	assign out_ch.status      = out_status_q;
	assign out_ch.end_of_scan = out_eos_q;

endmodule

>>> sv/mrnp_checker.sv
// Port-level checker for the multi-radix number text parser, with its bind.
// Depends on mrnp_pkg and the top level multi_radix_number_text_parser.
module mrnp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input mrnp_pkg::value_t  out_value,
	input mrnp_pkg::status_t out_status,
	input logic              out_eos
);
	import mrnp_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value)
			&& $stable(out_status) && $stable(out_eos))
		else $error("stalled result changed");

	// an empty output slot never blocks input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_status == ST_OK) || (out_status == ST_NONE)
			|| (out_status == ST_OVF))
		else $error("undefined status code");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status == ST_OVF) |-> (out_value == OVF_VALUE) && out_eos)
		else $error("overflow result malformed");

	a_no_number: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status == ST_NONE) |-> (out_value == '0) && out_eos)
		else $error("no-number result malformed");

endmodule

bind multi_radix_number_text_parser mrnp_checker u_mrnp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_value  (out_ch.value),
	.out_status (out_ch.status),
	.out_eos    (out_ch.end_of_scan)
);
